// ===== hw/rtl/tbbt_pkg.sv =====
`default_nettype none

package tbbt_pkg;

    // One input word: a reposition request or a period advance.
    typedef struct packed {
        logic        reposition;
        logic [31:0] frame;
        logic [13:0] period_frames;
        logic        force_beat;
    } t_in_word;

    // One result word: the musical position after the update.
    typedef struct packed {
        logic [30:0] bar_number;
        logic [6:0]  beat_in_bar;
        logic [15:0] tick_in_beat;
        logic [47:0] bar_start;
    } t_out_word;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TEMPO          = 2'd0;
    localparam logic [1:0] CFG_BEATS_PER_BAR  = 2'd1;
    localparam logic [1:0] CFG_TICKS_PER_BEAT = 2'd2;
    localparam logic [1:0] CFG_SAMPLE_RATE    = 2'd3;

    // Register reset values.
    localparam logic [25:0] TEMPO_RST = 26'd7864320;
    localparam logic [6:0]  BPB_RST   = 7'd4;
    localparam logic [15:0] TPB_RST   = 16'd1920;
    localparam logic [18:0] SR_RST    = 19'd48000;

    // Saturation limits of the bar counters.
    localparam logic [30:0] BAR_MAX   = 31'h7FFF_FFFF;
    localparam logic [47:0] START_MAX = 48'hFFFF_FFFF_FFFF;

endpackage

`default_nettype wire

// ===== hw/rtl/tempo_bar_beat_tick_clock_core.sv =====
// Tempo clock that tracks bar, beat and tick, one input word per audio period.
// Input channel (i_valid/o_ready, i_data): a reposition word converts its
// absolute frame to a position; an advance word moves the position on by
// period_frames at the configured tempo. force_beat snaps to the nearest beat.
// Output channel (o_valid/i_ready, o_data): one result word per input word.
// Configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data)
// is always ready; write it only while no word is in flight.
// The arithmetic runs one bit a cycle: a shift-add multiplier (16 + 32
// steps) and a restoring divider that runs 74 + TICK_FRAC_BITS steps for the
// frame scaling, then 53 steps each for the splits by ticks per beat and
// beats per bar. o_ready is high only while the sequencer is idle, so one
// word is in work at a time and a new word is taken only after the last one
// has been loaded into the output register.
// A finished word sits in the output register while the next input word is
// accepted; if the receiver still stalls when the next word is done, the
// sequencer holds in its last step until the register frees.
// Reset (synchronous, active low) restores register defaults and puts the
// position at bar 1, beat 1, bar start 0 with an empty output register.
`default_nettype none

module tempo_bar_beat_tick_clock_core #(
    parameter int TICK_FRAC_BITS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  tbbt_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  wire                 i_ready,
    output tbbt_pkg::t_out_word o_data,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [1:0]          i_cfg_index,
    input  wire  [25:0]         i_cfg_data
);
    import tbbt_pkg::*;

    localparam int FB  = TICK_FRAC_BITS;
    localparam int PW  = 74;          // product width
    localparam int XW  = 53;          // whole tick count width
    localparam int QW  = XW + FB;     // quotient with fraction
    localparam int DW  = 41;          // divisor and remainder width
    localparam int TW  = XW + 2;      // signed sum width
    localparam int AIW = 18;          // accumulator integer width
    localparam int CW  = $clog2(PW + FB + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL1  = 4'd1;
    localparam logic [3:0] S_MUL2  = 4'd2;
    localparam logic [3:0] S_DIV1  = 4'd3;
    localparam logic [3:0] S_POST1 = 4'd4;
    localparam logic [3:0] S_DIV2  = 4'd5;
    localparam logic [3:0] S_POST2 = 4'd6;
    localparam logic [3:0] S_DIV3  = 4'd7;
    localparam logic [3:0] S_FIN1  = 4'd8;
    localparam logic [3:0] S_FIN2  = 4'd9;
    localparam logic [3:0] S_FORCE = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    // Control and architectural state.
    logic [3:0]          r_state;
    logic [CW-1:0]       r_cnt;
    logic [25:0]         r_tempo;
    logic [6:0]          r_bpb;
    logic [15:0]         r_tpb;
    logic [18:0]         r_sr;
    logic signed [AIW-1:0] r_acc_int;
    logic [FB-1:0]       r_acc_frac;
    logic [30:0]         r_bar;
    logic [6:0]          r_beat;
    logic [47:0]         r_start;
    logic [15:0]         r_tick;
    logic                r_out_valid;
    t_out_word           r_out;

    // Datapath registers.
    logic                r_repos;
    logic                r_force;
    logic [31:0]         r_b;
    logic [PW-1:0]       r_prod;
    logic [PW-1:0]       r_mcand;
    logic [31:0]         r_mplier;
    logic [PW-1:0]       r_ds;
    logic [DW-1:0]       r_rem;
    logic [DW-1:0]       r_dv;
    logic [QW-1:0]       r_q;
    logic [XW-1:0]       r_x;
    logic                r_neg;
    logic [AIW-1:0]      r_accv;
    logic                r_rb;
    logic [FB-1:0]       r_fsum;
    logic                r_e;
    logic                r_skip;
    logic [22:0]         r_a;
    logic [22:0]         r_m2;
    logic [22:0]         r_span;
    logic [TW-1:0]       r_part;

    // Zero registers act as one.
    logic [15:0] tpb_e;
    logic [6:0]  bpb_e;
    logic [18:0] sr_e;
    logic [24:0] sr60;
    logic [DW-1:0] div_d;

    assign tpb_e = (r_tpb == 16'd0) ? 16'd1 : r_tpb;
    assign bpb_e = (r_bpb == 7'd0) ? 7'd1 : r_bpb;
    assign sr_e  = (r_sr == 19'd0) ? 19'd1 : r_sr;
    assign sr60  = {sr_e, 6'b0} - {4'b0, sr_e, 2'b0};
    assign div_d = {sr60, 16'b0};

    // Shift-add multiplier step.
    logic [PW-1:0] mul_sum;
    assign mul_sum = r_prod + (r_mplier[0] ? r_mcand : {PW{1'b0}});

    // Restoring divider step.
    logic [DW:0]   div_t;
    logic          div_ge;
    logic [DW:0]   div_sub;
    logic [DW-1:0] div_rem;
    assign div_t   = {r_rem, r_ds[PW-1]};
    assign div_ge  = div_t >= {1'b0, r_dv};
    assign div_sub = div_t - {1'b0, r_dv};
    assign div_rem = div_ge ? div_sub[DW-1:0] : div_t[DW-1:0];

    logic last;
    assign last = (r_cnt == CW'(1));

    // Accumulate the increment after the frame scaling.
    logic [XW-1:0]        p1_whole;
    logic [FB:0]          p1_fsum;
    logic signed [TW-1:0] p1_total;
    logic [XW-1:0]        p1_xadv;
    logic [XW-1:0]        p1_x;
    assign p1_whole = r_q[QW-1:FB];
    assign p1_fsum  = {1'b0, r_acc_frac} + {1'b0, r_q[FB-1:0]};
    assign p1_total = $signed({{(TW-AIW){r_acc_int[AIW-1]}}, r_acc_int})
                    + $signed({2'b0, p1_whole})
                    + $signed({{(TW-1){1'b0}}, p1_fsum[FB]});
    assign p1_xadv  = p1_total[TW-1] ? {XW{1'b0}}
                    : p1_total[XW-1:0] + {{(XW-1){1'b0}}, p1_fsum[FB-1]};
    assign p1_x     = r_repos ? p1_whole : p1_xadv;

    // Beats carried after the split by ticks per beat.
    logic [XW-1:0] p2_n;
    logic [15:0]   p2_tick;
    logic          p2_e;
    logic [6:0]    p2_am;
    logic [XW-1:0] p2_t;
    logic [6:0]    beat_m1;
    assign p2_n    = r_q[XW-1:0];
    assign p2_tick = r_rem[15:0];
    assign beat_m1 = r_beat - 7'd1;
    assign p2_e    = !r_repos && (p2_n != {XW{1'b0}}) && (r_beat >= bpb_e);
    assign p2_am   = p2_e ? (bpb_e - 7'd1) : beat_m1;
    assign p2_t    = r_repos ? p2_n
                   : (p2_e ? p2_n - {{(XW-1){1'b0}}, 1'b1}
                           : p2_n + {{(XW-7){1'b0}}, beat_m1});

    // Bar update after the split by beats per bar.
    logic [XW-1:0] f1_bars;
    logic [XW:0]   f1_sum;
    logic [30:0]   f1_bar;
    logic [TW-1:0] f1_part;
    assign f1_bars = r_q[XW-1:0];
    assign f1_sum  = {{(XW-30){1'b0}}, r_bar} + {1'b0, f1_bars}
                   + {{XW{1'b0}}, r_e};
    always_comb begin
        if (r_repos) begin
            f1_bar = (f1_bars >= {{(XW-31){1'b0}}, BAR_MAX}) ? BAR_MAX
                   : f1_bars[30:0] + 31'd1;
        end else begin
            f1_bar = (f1_sum > {{(XW-30){1'b0}}, BAR_MAX}) ? BAR_MAX : f1_sum[30:0];
        end
    end
    assign f1_part = (r_repos ? {TW{1'b0}} : {{(TW-48){1'b0}}, r_start})
                   + (r_repos ? {TW{1'b0}} : {{(TW-23){1'b0}}, r_a})
                   + {2'b0, r_x} - {{(TW-16){1'b0}}, r_tick};

    logic [TW-1:0] f2_diff;
    logic [47:0]   f2_start;
    assign f2_diff  = r_part - {{(TW-23){1'b0}}, r_m2};
    assign f2_start = (f2_diff[TW-1:48] != '0) ? START_MAX : f2_diff[47:0];

    // Snap to the nearest beat.
    logic [48:0] fc_sum;
    logic        fc_up;
    assign fc_sum = {1'b0, r_start} + {26'b0, r_span};
    assign fc_up  = r_tick > {1'b0, tpb_e[15:1]};

    logic in_acc;
    logic out_load;
    assign in_acc   = i_valid && o_ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    // Sequencer, configuration and position state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_tempo     <= TEMPO_RST;
            r_bpb       <= BPB_RST;
            r_tpb       <= TPB_RST;
            r_sr        <= SR_RST;
            r_acc_int   <= '0;
            r_acc_frac  <= '0;
            r_bar       <= 31'd1;
            r_beat      <= 7'd1;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TEMPO:          r_tempo <= i_cfg_data;
                    CFG_BEATS_PER_BAR:  r_bpb   <= i_cfg_data[6:0];
                    CFG_TICKS_PER_BEAT: r_tpb   <= i_cfg_data[15:0];
                    CFG_SAMPLE_RATE:    r_sr    <= i_cfg_data[18:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_MUL1;
                        r_cnt   <= CW'(16);
                    end
                end
                S_MUL1: begin
                    r_cnt <= r_cnt - CW'(1);
                    if (last) begin
                        r_state <= S_MUL2;
                        r_cnt   <= CW'(32);
                    end
                end
                S_MUL2: begin
                    r_cnt <= r_cnt - CW'(1);
                    if (last) begin
                        r_state <= S_DIV1;
                        r_cnt   <= CW'(PW + FB);
                    end
                end
                S_DIV1: begin
                    r_cnt <= r_cnt - CW'(1);
                    if (last) begin
                        r_state <= S_POST1;
                    end
                end
                S_POST1: begin
                    r_state <= S_DIV2;
                    r_cnt   <= CW'(XW);
                end
                S_DIV2: begin
                    r_cnt <= r_cnt - CW'(1);
                    if (last) begin
                        r_state <= S_POST2;
                    end
                end
                S_POST2: begin
                    r_state <= S_DIV3;
                    r_cnt   <= CW'(XW);
                    if (r_repos) begin
                        r_acc_int  <= $signed({2'b0, p2_tick});
                        r_acc_frac <= '0;
                    end else begin
                        r_acc_int  <= r_neg ? $signed(r_accv)
                                    : $signed({2'b0, p2_tick} - {{(AIW-1){1'b0}}, r_rb});
                        r_acc_frac <= r_fsum;
                    end
                end
                S_DIV3: begin
                    r_cnt <= r_cnt - CW'(1);
                    if (last) begin
                        r_state <= S_FIN1;
                    end
                end
                S_FIN1: begin
                    r_state <= S_FIN2;
                    if (!r_skip) begin
                        r_bar  <= f1_bar;
                        r_beat <= r_rem[6:0] + 7'd1;
                    end
                end
                S_FIN2: begin
                    r_state <= S_FORCE;
                    if (!r_skip) begin
                        r_start <= f2_start;
                    end
                end
                S_FORCE: begin
                    r_state <= S_DONE;
                    if (r_force) begin
                        r_acc_int  <= '0;
                        r_acc_frac <= '0;
                        if (fc_up) begin
                            if (r_beat >= bpb_e) begin
                                r_beat  <= 7'd1;
                                r_bar   <= (r_bar == BAR_MAX) ? BAR_MAX : r_bar + 31'd1;
                                r_start <= fc_sum[48] ? START_MAX : fc_sum[47:0];
                            end else begin
                                r_beat <= r_beat + 7'd1;
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Arithmetic datapath, no reset needed.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_repos  <= i_data.reposition;
                    r_force  <= i_data.force_beat;
                    r_b      <= i_data.reposition ? i_data.frame
                              : {18'b0, i_data.period_frames};
                    r_prod   <= '0;
                    r_mcand  <= {{(PW-26){1'b0}}, r_tempo};
                    r_mplier <= {16'b0, tpb_e};
                end
            end
            S_MUL1: begin
                r_prod   <= mul_sum;
                r_mcand  <= {r_mcand[PW-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[31:1]};
                if (last) begin
                    r_prod   <= '0;
                    r_mcand  <= mul_sum;
                    r_mplier <= r_b;
                end
            end
            S_MUL2: begin
                r_prod   <= mul_sum;
                r_mcand  <= {r_mcand[PW-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[31:1]};
                if (last) begin
                    r_ds  <= mul_sum;
                    r_rem <= '0;
                    r_q   <= '0;
                    r_dv  <= div_d;
                end
            end
            S_DIV1, S_DIV2, S_DIV3: begin
                r_rem <= div_rem;
                r_q   <= {r_q[QW-2:0], div_ge};
                r_ds  <= {r_ds[PW-2:0], 1'b0};
            end
            S_POST1: begin
                r_x    <= p1_x;
                r_neg  <= !r_repos && p1_total[TW-1];
                r_accv <= p1_total[AIW-1:0];
                r_rb   <= p1_fsum[FB-1];
                r_fsum <= p1_fsum[FB-1:0];
                r_ds   <= {p1_x, {(PW-XW){1'b0}}};
                r_rem  <= '0;
                r_q    <= '0;
                r_dv   <= {{(DW-16){1'b0}}, tpb_e};
            end
            S_POST2: begin
                r_tick <= p2_tick;
                r_e    <= p2_e;
                r_skip <= !r_repos && (p2_n == {XW{1'b0}});
                r_a    <= {16'b0, p2_am} * {7'b0, tpb_e};
                r_ds   <= {p2_t, {(PW-XW){1'b0}}};
                r_rem  <= '0;
                r_q    <= '0;
                r_dv   <= {{(DW-7){1'b0}}, bpb_e};
            end
            S_FIN1: begin
                r_m2   <= {16'b0, r_rem[6:0]} * {7'b0, tpb_e};
                r_span <= {16'b0, bpb_e} * {7'b0, tpb_e};
                r_part <= f1_part;
            end
            S_FORCE: begin
                if (r_force) begin
                    r_tick <= '0;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    r_out.bar_number   <= r_bar;
                    r_out.beat_in_bar  <= r_beat;
                    r_out.tick_in_beat <= r_tick;
                    r_out.bar_start    <= r_start;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire
